[hdl/tch_pkg.sv]
// Shared constants, widths and the arctangent table for the tilt-compensated
// heading core. Used by every module in this folder; depends on nothing.
`timescale 1ns / 1ps

package tch_pkg;

   localparam int ANGLE_W   = 36;
   localparam int ROT_W     = 34;
   localparam int TRIG_W    = 32;
   localparam int IQ        = 30;
   localparam int TABLE_LEN = 24;

   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q = 36'sd1686629713;
   localparam logic signed [ANGLE_W-1:0] PI_Q      = 36'sd3373259426;
   localparam logic signed [ANGLE_W-1:0] TWO_PI_Q  = 36'sd6746518852;
   localparam logic signed [ROT_W-1:0]   GAIN_Q    = 34'sd652032874;

   localparam logic signed [ANGLE_W-1:0] ATAN_Q30 [TABLE_LEN] = '{
      36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
      36'sd67021686,  36'sd33543515,  36'sd16775850,  36'sd8388437,
      36'sd4194282,   36'sd2097149,   36'sd1048575,   36'sd524287,
      36'sd262143,    36'sd131071,    36'sd65535,     36'sd32767,
      36'sd16383,     36'sd8191,      36'sd4095,      36'sd2047,
      36'sd1023,      36'sd511,       36'sd255,       36'sd127
   };

endpackage

[hdl/tch_cordic_cell.sv]
// One CORDIC micro-rotation cell with a fixed shift, in rotation or vectoring mode.
// Depends on tch_pkg for the angle width and the arctangent table.
`timescale 1ns / 1ps

module tch_cordic_cell import tch_pkg::*; #(
   parameter int XW     = 34,
   parameter int SHIFT  = 0,
   parameter bit VECTOR = 1'b0,
   parameter int SIDE_W = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      src_valid,
   input  logic signed [XW-1:0]      src_x,
   input  logic signed [XW-1:0]      src_y,
   input  logic signed [ANGLE_W-1:0] src_z,
   input  logic [SIDE_W-1:0]         src_side,
   output logic                      dst_valid,
   output logic signed [XW-1:0]      dst_x,
   output logic signed [XW-1:0]      dst_y,
   output logic signed [ANGLE_W-1:0] dst_z,
   output logic [SIDE_W-1:0]         dst_side
);

   logic                      valid_ff;
   logic signed [XW-1:0]      x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0] z_ff, z_in;
   logic [SIDE_W-1:0]         side_ff;
   logic                      pos;
   logic signed [XW-1:0]      xs, ys;

   always_comb begin
      pos = VECTOR ? src_y[XW-1] : !src_z[ANGLE_W-1];
      xs = src_x >>> SHIFT;
      ys = src_y >>> SHIFT;
      if (pos) begin
         x_in = src_x - ys;
         y_in = src_y + xs;
         z_in = src_z - ATAN_Q30[SHIFT];
      end else begin
         x_in = src_x + ys;
         y_in = src_y - xs;
         z_in = src_z + ATAN_Q30[SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= src_side;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_x     = x_ff;
   assign dst_y     = y_ff;
   assign dst_z     = z_ff;
   assign dst_side  = side_ff;

endmodule

[hdl/tch_angle_reduce.sv]
// Reduces roll and pitch modulo two pi and folds them into the CORDIC range.
// Three registered stages; depends on tch_pkg for the angle constants.
`timescale 1ns / 1ps

module tch_angle_reduce import tch_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int SIDE_W          = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      src_valid,
   input  logic signed [15:0]        src_roll,
   input  logic signed [15:0]        src_pitch,
   input  logic [SIDE_W-1:0]         src_side,
   output logic                      dst_valid,
   output logic signed [ANGLE_W-1:0] dst_z [2],
   output logic [1:0]                dst_neg,
   output logic [SIDE_W-1:0]         dst_side
);

   localparam int S = IQ - ANGLE_FRAC_BITS;
   localparam longint RECIP = (longint'(1) << (S + 20)) / longint'(TWO_PI_Q);
   localparam logic [31:0] RECIP_W = 32'(RECIP);

   logic [2:0]                valid_ff;
   logic [SIDE_W-1:0]         side1_ff, side2_ff, side3_ff;
   logic [16:0]               mag_ff [2], mag_in [2];
   logic [1:0]                sgn_ff, sgn_in;
   logic [7:0]                q_ff [2], q_in [2];
   logic signed [ANGLE_W-1:0] zt_ff [2], zt_in [2];
   logic signed [ANGLE_W-1:0] z_ff [2], z_in [2];
   logic [1:0]                neg_ff, neg_in;

   logic signed [15:0] raw [2];
   logic signed [16:0] ext [2];
   logic [48:0]        prod [2];
   logic signed [40:0] r [2];
   logic signed [ANGLE_W-1:0] w [2];

   assign raw[0] = src_roll;
   assign raw[1] = src_pitch;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         ext[k]    = 17'(raw[k]);
         sgn_in[k] = raw[k][15];
         mag_in[k] = sgn_in[k] ? 17'(-ext[k]) : 17'(ext[k]);
         prod[k]   = 49'(mag_in[k]) * 49'(RECIP_W);
         q_in[k]   = 8'(prod[k] >> 20);

         r[k] = $signed(41'(mag_ff[k]) << S) - $signed(41'(q_ff[k]) * 41'(TWO_PI_Q));
         if (r[k] >= 41'(TWO_PI_Q)) begin
            r[k] = r[k] - 41'(TWO_PI_Q);
         end
         zt_in[k] = sgn_ff[k] ? -ANGLE_W'(r[k]) : ANGLE_W'(r[k]);

         w[k] = zt_ff[k];
         if (w[k] > PI_Q) begin
            w[k] = w[k] - TWO_PI_Q;
         end
         if (w[k] < -PI_Q) begin
            w[k] = w[k] + TWO_PI_Q;
         end
         neg_in[k] = 1'b0;
         if (w[k] > HALF_PI_Q) begin
            w[k] = w[k] - PI_Q;
            neg_in[k] = 1'b1;
         end else if (w[k] < -HALF_PI_Q) begin
            w[k] = w[k] + PI_Q;
            neg_in[k] = 1'b1;
         end
         z_in[k] = w[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], src_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= mag_in;
         sgn_ff   <= sgn_in;
         q_ff     <= q_in;
         zt_ff    <= zt_in;
         z_ff     <= z_in;
         neg_ff   <= neg_in;
         side1_ff <= src_side;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
      end
   end

   assign dst_valid = valid_ff[2];
   assign dst_z     = z_ff;
   assign dst_neg   = neg_ff;
   assign dst_side  = side3_ff;

endmodule

[hdl/tch_tilt_project.sv]
// Projects the field into the horizontal plane and prepares the vectoring input.
// Six registered stages, with the multiplies in the second and fourth; depends on tch_pkg.
`timescale 1ns / 1ps

module tch_tilt_project import tch_pkg::*; #(
   parameter int FIELD_WIDTH = 18,
   parameter int VW          = 41
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          src_valid,
   input  logic signed [ROT_W-1:0]       src_sr,
   input  logic signed [ROT_W-1:0]       src_cr,
   input  logic                          src_neg_r,
   input  logic signed [ROT_W-1:0]       src_sp,
   input  logic signed [ROT_W-1:0]       src_cp,
   input  logic                          src_neg_p,
   input  logic signed [FIELD_WIDTH-1:0] src_fx,
   input  logic signed [FIELD_WIDTH-1:0] src_fy,
   input  logic signed [FIELD_WIDTH-1:0] src_fz,
   output logic                          dst_valid,
   output logic signed [VW-1:0]          dst_x,
   output logic signed [VW-1:0]          dst_y,
   output logic signed [ANGLE_W-1:0]     dst_z,
   output logic                          dst_zero
);

   localparam int FW  = FIELD_WIDTH;
   localparam int MW  = FW + TRIG_W;
   localparam int HXW = FW + 20;

   logic [5:0] valid_ff;

   logic signed [TRIG_W-1:0] sr0_ff, cr0_ff, sp0_ff, cp0_ff;
   logic signed [TRIG_W-1:0] sr0_in, cr0_in, sp0_in, cp0_in;
   logic signed [FW-1:0]     fx0_ff, fy0_ff, fz0_ff, fy1_ff, fz1_ff, fy2_ff, fz2_ff;

   logic signed [2*TRIG_W-1:0] spsr1_ff, spcr1_ff;
   logic signed [MW-1:0]       fycr1_ff, fzsr1_ff, fxcp1_ff;

   logic signed [TRIG_W-1:0] spsr2_ff, spsr2_in, spcr2_ff, spcr2_in;
   logic signed [HXW-1:0]    hy2_ff, hy2_in, fxcp2_ff, fxcp2_in;

   logic signed [MW-1:0]  m1_ff, m2_ff;
   logic signed [HXW-1:0] hy3_ff, fxcp3_ff, hy4_ff;
   logic signed [HXW-1:0] hx4_ff, hx4_in;

   logic signed [VW-1:0]      x5_ff, x5_in, y5_ff, y5_in;
   logic signed [ANGLE_W-1:0] z5_ff, z5_in;
   logic                      zero5_ff, zero5_in;

   always_comb begin
      sr0_in = src_neg_r ? TRIG_W'(-src_sr) : TRIG_W'(src_sr);
      cr0_in = src_neg_r ? TRIG_W'(-src_cr) : TRIG_W'(src_cr);
      sp0_in = src_neg_p ? TRIG_W'(-src_sp) : TRIG_W'(src_sp);
      cp0_in = src_neg_p ? TRIG_W'(-src_cp) : TRIG_W'(src_cp);

      spsr2_in = TRIG_W'(spsr1_ff >>> IQ);
      spcr2_in = TRIG_W'(spcr1_ff >>> IQ);
      hy2_in   = HXW'(fycr1_ff >>> 14) + HXW'(fzsr1_ff >>> 14);
      fxcp2_in = HXW'(fxcp1_ff >>> 14);

      hx4_in = fxcp3_ff + HXW'(m1_ff >>> 14) - HXW'(m2_ff >>> 14);

      zero5_in = (hx4_ff == '0) && (hy4_ff == '0);
      if (hx4_ff[HXW-1]) begin
         x5_in = -VW'(hx4_ff);
         y5_in = VW'(hy4_ff);
         z5_in = PI_Q;
      end else begin
         x5_in = VW'(hx4_ff);
         y5_in = -VW'(hy4_ff);
         z5_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], src_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sr0_ff <= sr0_in;
         cr0_ff <= cr0_in;
         sp0_ff <= sp0_in;
         cp0_ff <= cp0_in;
         fx0_ff <= src_fx;
         fy0_ff <= src_fy;
         fz0_ff <= src_fz;

         spsr1_ff <= sp0_ff * sr0_ff;
         spcr1_ff <= sp0_ff * cr0_ff;
         fycr1_ff <= MW'(fy0_ff) * MW'(cr0_ff);
         fzsr1_ff <= MW'(fz0_ff) * MW'(sr0_ff);
         fxcp1_ff <= MW'(fx0_ff) * MW'(cp0_ff);
         fy1_ff   <= fy0_ff;
         fz1_ff   <= fz0_ff;

         spsr2_ff <= spsr2_in;
         spcr2_ff <= spcr2_in;
         hy2_ff   <= hy2_in;
         fxcp2_ff <= fxcp2_in;
         fy2_ff   <= fy1_ff;
         fz2_ff   <= fz1_ff;

         m1_ff    <= MW'(fy2_ff) * MW'(spsr2_ff);
         m2_ff    <= MW'(fz2_ff) * MW'(spcr2_ff);
         hy3_ff   <= hy2_ff;
         fxcp3_ff <= fxcp2_ff;

         hx4_ff <= hx4_in;
         hy4_ff <= hy3_ff;

         x5_ff    <= x5_in;
         y5_ff    <= y5_in;
         z5_ff    <= z5_in;
         zero5_ff <= zero5_in;
      end
   end

   assign dst_valid = valid_ff[5];
   assign dst_x     = x5_ff;
   assign dst_y     = y5_ff;
   assign dst_z     = z5_ff;
   assign dst_zero  = zero5_ff;

endmodule

[hdl/tilt_compensated_heading_core.sv]
// Top level of the tilt-compensated heading core: angle reduction, two CORDIC
// rotation chains, tilt projection, a vectoring chain and heading rounding.
// Depends on tch_pkg, tch_angle_reduce, tch_cordic_cell and tch_tilt_project.
//
//   channel   direction   ports
//   request   in          req_valid, req_ready, req_roll_angle .. req_field_z
//   response  out         rsp_valid, rsp_ready, rsp_heading
//
// One sample is accepted every cycle unless the pipeline is held; each chain has N
// CORDIC cells, where N = min(CORDIC_STAGES, 24).
// The whole pipeline advances together; it holds only while a result waits in
// the output register and the response side is not ready.
// Reset is synchronous and clears the valid bits of every stage.
`timescale 1ns / 1ps

module tilt_compensated_heading_core import tch_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int FIELD_WIDTH     = 18,
   parameter int CORDIC_STAGES   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [15:0]            req_roll_angle,
   input  logic signed [15:0]            req_pitch_angle,
   input  logic signed [FIELD_WIDTH-1:0] req_field_x,
   input  logic signed [FIELD_WIDTH-1:0] req_field_y,
   input  logic signed [FIELD_WIDTH-1:0] req_field_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [15:0]                   rsp_heading
);

   localparam int N      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int FW     = FIELD_WIDTH;
   localparam int VW     = FIELD_WIDTH + 23;
   localparam int S      = IQ - ANGLE_FRAC_BITS;
   localparam int RSIDE  = 1 + 3 * FW;
   localparam longint HALF = longint'(1) << (S - 1);
   localparam longint FULL = (longint'(TWO_PI_Q) + HALF) >> S;
   localparam logic [35:0] HALF_W = 36'(HALF);
   localparam logic [35:0] FULL_W = 36'(FULL);

   logic en;
   logic out_valid_ff;
   logic [15:0] heading_ff, heading_in;

   logic                      red_valid;
   logic signed [ANGLE_W-1:0] red_z [2];
   logic [1:0]                red_neg;
   logic [3*FW-1:0]           red_side;

   logic                      rv [0:N];
   logic                      pv [0:N];
   logic signed [ROT_W-1:0]   rx [0:N];
   logic signed [ROT_W-1:0]   ry [0:N];
   logic signed [ANGLE_W-1:0] rz [0:N];
   logic [RSIDE-1:0]          rs [0:N];
   logic signed [ROT_W-1:0]   px [0:N];
   logic signed [ROT_W-1:0]   py [0:N];
   logic signed [ANGLE_W-1:0] pz [0:N];
   logic                      ps [0:N];

   logic                      vv [0:N];
   logic signed [VW-1:0]      vx [0:N];
   logic signed [VW-1:0]      vy [0:N];
   logic signed [ANGLE_W-1:0] vz [0:N];
   logic                      vs [0:N];

   logic signed [ANGLE_W-1:0] zw;
   logic [35:0]               hsum;

   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   tch_angle_reduce #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .SIDE_W(3 * FW)
   ) u_reduce (
      .clock(clock),
      .reset(reset),
      .en(en),
      .src_valid(req_valid),
      .src_roll(req_roll_angle),
      .src_pitch(req_pitch_angle),
      .src_side({req_field_x, req_field_y, req_field_z}),
      .dst_valid(red_valid),
      .dst_z(red_z),
      .dst_neg(red_neg),
      .dst_side(red_side)
   );

   assign rv[0] = red_valid;
   assign rx[0] = GAIN_Q;
   assign ry[0] = '0;
   assign rz[0] = red_z[0];
   assign rs[0] = {red_neg[0], red_side};
   assign pv[0] = red_valid;
   assign px[0] = GAIN_Q;
   assign py[0] = '0;
   assign pz[0] = red_z[1];
   assign ps[0] = red_neg[1];

   for (genvar i = 0; i < N; i++) begin : g_rot
      tch_cordic_cell #(
         .XW(ROT_W), .SHIFT(i), .VECTOR(1'b0), .SIDE_W(RSIDE)
      ) u_roll (
         .clock(clock), .reset(reset), .en(en),
         .src_valid(rv[i]), .src_x(rx[i]), .src_y(ry[i]), .src_z(rz[i]), .src_side(rs[i]),
         .dst_valid(rv[i+1]), .dst_x(rx[i+1]), .dst_y(ry[i+1]), .dst_z(rz[i+1]),
         .dst_side(rs[i+1])
      );
      tch_cordic_cell #(
         .XW(ROT_W), .SHIFT(i), .VECTOR(1'b0), .SIDE_W(1)
      ) u_pitch (
         .clock(clock), .reset(reset), .en(en),
         .src_valid(pv[i]), .src_x(px[i]), .src_y(py[i]), .src_z(pz[i]), .src_side(ps[i]),
         .dst_valid(pv[i+1]), .dst_x(px[i+1]), .dst_y(py[i+1]), .dst_z(pz[i+1]),
         .dst_side(ps[i+1])
      );
   end

   tch_tilt_project #(
      .FIELD_WIDTH(FIELD_WIDTH),
      .VW(VW)
   ) u_project (
      .clock(clock),
      .reset(reset),
      .en(en),
      .src_valid(rv[N]),
      .src_sr(ry[N]),
      .src_cr(rx[N]),
      .src_neg_r(rs[N][RSIDE-1]),
      .src_sp(py[N]),
      .src_cp(px[N]),
      .src_neg_p(ps[N]),
      .src_fx(rs[N][3*FW-1:2*FW]),
      .src_fy(rs[N][2*FW-1:FW]),
      .src_fz(rs[N][FW-1:0]),
      .dst_valid(vv[0]),
      .dst_x(vx[0]),
      .dst_y(vy[0]),
      .dst_z(vz[0]),
      .dst_zero(vs[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_vec
      tch_cordic_cell #(
         .XW(VW), .SHIFT(i), .VECTOR(1'b1), .SIDE_W(1)
      ) u_vec (
         .clock(clock), .reset(reset), .en(en),
         .src_valid(vv[i]), .src_x(vx[i]), .src_y(vy[i]), .src_z(vz[i]), .src_side(vs[i]),
         .dst_valid(vv[i+1]), .dst_x(vx[i+1]), .dst_y(vy[i+1]), .dst_z(vz[i+1]),
         .dst_side(vs[i+1])
      );
   end

   always_comb begin
      zw = vz[N];
      if (zw < 0) begin
         zw = zw + TWO_PI_Q;
      end
      if (zw >= TWO_PI_Q) begin
         zw = zw - TWO_PI_Q;
      end
      hsum = (36'(zw) + HALF_W) >> S;
      if (vs[N] || (hsum >= FULL_W)) begin
         heading_in = '0;
      end else begin
         heading_in = hsum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= vv[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         heading_ff <= heading_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_heading = heading_ff;

`ifndef SYNTHESIS
   a_chains_aligned : assert property (@(posedge clock) disable iff (reset)
      rv[N] == pv[N])
      else $error("roll and pitch rotation chains out of step");

   a_stall_source : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a waiting result");

   a_reduce_range : assert property (@(posedge clock) disable iff (reset)
      red_valid |-> (red_z[0] <= HALF_PI_Q && red_z[0] >= -HALF_PI_Q &&
                     red_z[1] <= HALF_PI_Q && red_z[1] >= -HALF_PI_Q))
      else $error("reduced angle outside the CORDIC range");
`endif

endmodule

[sim/tch_heading_checker.sv]
// Checker for the tilt-compensated heading core: it watches both channels, predicts
// each heading from the accepted sample and compares it with the returned one.
// Depends on tch_pkg for the CORDIC constants and the arctangent table.
`timescale 1ns / 1ps

module tch_heading_checker import tch_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int FIELD_WIDTH     = 18,
   parameter int CORDIC_STAGES   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [15:0]            req_roll_angle,
   input  logic signed [15:0]            req_pitch_angle,
   input  logic signed [FIELD_WIDTH-1:0] req_field_x,
   input  logic signed [FIELD_WIDTH-1:0] req_field_y,
   input  logic signed [FIELD_WIDTH-1:0] req_field_z,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [15:0]                   rsp_heading,
   output int                            fail_count,
   output int                            pending_count
);

   localparam int STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int SHIFT  = IQ - ANGLE_FRAC_BITS;

   logic [15:0] expected_headings [$];

   function automatic void angle_sin_cos(input logic signed [15:0] raw,
                                         output longint sin_q, output longint cos_q);
      longint z;
      longint x;
      longint y;
      longint t;
      bit     flip;
      z = longint'(raw) * (longint'(1) << SHIFT);
      x = longint'(GAIN_Q);
      y = 0;
      flip = 0;
      z = z % longint'(TWO_PI_Q);
      if (z > longint'(PI_Q)) z -= longint'(TWO_PI_Q);
      if (z < -longint'(PI_Q)) z += longint'(TWO_PI_Q);
      if (z > longint'(HALF_PI_Q)) begin
         z -= longint'(PI_Q);
         flip = 1;
      end else if (z < -longint'(HALF_PI_Q)) begin
         z += longint'(PI_Q);
         flip = 1;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i); y = y + (x >>> i); x = t; z -= longint'(ATAN_Q30[i]);
         end else begin
            t = x + (y >>> i); y = y - (x >>> i); x = t; z += longint'(ATAN_Q30[i]);
         end
      end
      sin_q = flip ? -y : y;
      cos_q = flip ? -x : x;
   endfunction

   function automatic longint vector_angle(input longint yv, input longint xv);
      longint z;
      longint t;
      z = 0;
      if (xv < 0) begin
         xv = -xv; yv = -yv; z = longint'(PI_Q);
      end
      for (int i = 0; i < STAGES; i++) begin
         if (yv < 0) begin
            t = xv - (yv >>> i); yv = yv + (xv >>> i); xv = t; z -= longint'(ATAN_Q30[i]);
         end else begin
            t = xv + (yv >>> i); yv = yv - (xv >>> i); xv = t; z += longint'(ATAN_Q30[i]);
         end
      end
      if (z < 0) z += longint'(TWO_PI_Q);
      if (z >= longint'(TWO_PI_Q)) z -= longint'(TWO_PI_Q);
      return z;
   endfunction

   function automatic logic [15:0] predict_heading(input logic signed [15:0] roll,
         input logic signed [15:0] pitch, input logic signed [FIELD_WIDTH-1:0] fx,
         input logic signed [FIELD_WIDTH-1:0] fy, input logic signed [FIELD_WIDTH-1:0] fz);
      longint sr, cr, sp, cp, spsr, spcr, hx, hy, z, h, full, half;
      angle_sin_cos(roll, sr, cr);
      angle_sin_cos(pitch, sp, cp);
      spsr = (sp * sr) >>> IQ;
      spcr = (sp * cr) >>> IQ;
      hy = ((longint'(fy) * cr) >>> 14) + ((longint'(fz) * sr) >>> 14);
      hx = ((longint'(fx) * cp) >>> 14) + ((longint'(fy) * spsr) >>> 14)
         - ((longint'(fz) * spcr) >>> 14);
      if (hx == 0 && hy == 0) return 16'd0;
      half = longint'(1) << (SHIFT - 1);
      z = vector_angle(-hy, hx);
      h = (z + half) >>> SHIFT;
      full = (longint'(TWO_PI_Q) + half) >>> SHIFT;
      if (h >= full) h = 0;
      return h[15:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   assign pending_count = expected_headings.size();

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            expected_headings.push_back(predict_heading(req_roll_angle, req_pitch_angle,
                                                        req_field_x, req_field_y,
                                                        req_field_z));
         if (rsp_valid && rsp_ready) begin
            if (expected_headings.size() == 0)
               report_mismatch("unexpected heading transfer", rsp_heading, 16'd0);
            else if (rsp_heading !== expected_headings[0])
               report_mismatch("heading", rsp_heading, expected_headings.pop_front());
            else
               void'(expected_headings.pop_front());
         end
      end
   end

endmodule

[sim/tb_tilt_compensated_heading_core.sv]
// Testbench top for the tilt-compensated heading core: drives directed and random
// samples with random idling and stalls, and gives the verdict.
// Depends on tch_pkg, tilt_compensated_heading_core and tch_heading_checker.
`timescale 1ns / 1ps

module tb_tilt_compensated_heading_core;

   localparam int FW          = 18;
   localparam int STALL_LIMIT = 5000;
   localparam int LATENCY     = 2 * 16 + 10;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_ready;
   logic signed [15:0]   req_roll_angle = 0;
   logic signed [15:0]   req_pitch_angle = 0;
   logic signed [FW-1:0] req_field_x = 0;
   logic signed [FW-1:0] req_field_y = 0;
   logic signed [FW-1:0] req_field_z = 0;
   logic                 rsp_valid;
   logic                 rsp_ready = 0;
   logic [15:0]          rsp_heading;
   int                   fail_count;
   int                   pending_count;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   int                   hold_requests = 0;
   int                   quiet_cycles = 0;

   tilt_compensated_heading_core dut (.*);

   tch_heading_checker checker_i (.*);

   initial forever #1 clock = ~clock;

   initial begin
      int served;
      int hold_left;
      served = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (served != hold_requests) begin
            served = hold_requests;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_sample(input logic [15:0] roll, input logic [15:0] pitch,
                              input logic [FW-1:0] fx, input logic [FW-1:0] fy,
                              input logic [FW-1:0] fz);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1;
      req_roll_angle  <= roll;
      req_pitch_angle <= pitch;
      req_field_x     <= fx;
      req_field_y     <= fy;
      req_field_z     <= fz;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [FW-1:0] random_field();
      case ($urandom_range(5))
         0: return '0;
         1: return FW'($signed($urandom_range(64)) - 32);
         2: return {1'b0, {(FW-1){1'b1}}};
         3: return {1'b1, {(FW-1){1'b0}}};
         default: return FW'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_angle();
      case ($urandom_range(3))
         0: return 16'($signed($urandom_range(51472)) - 25736);
         1: return 16'($signed($urandom_range(8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random(input int count);
      repeat (count)
         send_sample(random_angle(), random_angle(), random_field(), random_field(),
                     random_field());
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_idle_pct = 7;
      recv_idle_pct = 68;
      send_sample(16'd0, 16'd0, 18'd0, 18'd0, 18'd0);
      send_sample(16'd0, 16'd0, 18'd1000, 18'd0, 18'd0);
      send_sample(16'd0, 16'd0, 18'd1000, -18'sd1, 18'd0);
      send_sample(16'd0, 16'd0, 18'd100000, 18'd1, 18'd0);
      send_sample(16'd0, 16'd0, -18'sd1000, 18'd0, 18'd0);
      send_sample(16'd0, 16'd0, 18'd0, 18'd1000, 18'd0);
      send_sample(16'd0, 16'd0, 18'd0, -18'sd1000, 18'd0);
      send_sample(16'd25736, 16'd25736, 18'h1ffff, 18'h1ffff, 18'h1ffff);
      send_sample(-16'sd25736, -16'sd25736, 18'h20000, 18'h20000, 18'h20000);
      send_sample(16'd25736, -16'sd25736, 18'h20000, 18'h1ffff, 18'h20000);
      send_sample(16'd12868, 16'd12868, 18'd5000, 18'd7000, -18'sd3000);
      send_sample(-16'sd12868, -16'sd12868, 18'd5000, -18'sd7000, 18'd3000);
      send_sample(16'd25736, 16'd0, 18'd20000, 18'd20000, 18'd20000);
      send_sample(16'd0, 16'd25736, 18'd20000, 18'd20000, 18'd20000);
      send_sample(16'h7fff, 16'h8000, 18'd12345, -18'sd23456, 18'd34567);
      send_sample(16'h8000, 16'h7fff, -18'sd1, 18'd1, -18'sd1);
      send_sample(16'd6000, -16'sd9000, 18'd0, 18'd0, 18'd1);
      send_sample(16'd0, 16'd0, 18'd1, 18'd0, 18'd0);
      send_sample(16'hffff, 16'h0001, 18'h1ffff, 18'h20000, 18'h1ffff);
      send_random(130);

      wait_drained();
      send_idle_pct = 68;
      recv_idle_pct = 7;
      send_random(140);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      send_random(80);
      wait_drained();
      send_random(80);

      wait_drained();
      repeat (LATENCY) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
